[hw/rtl/ukt_pkg.sv]
package ukt_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ENTRY_W   = KEY_BITS + DATA_BITS;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

  // Request codes.
  localparam req_t REQ_INSERT   = 3'd0;
  localparam req_t REQ_DELETE   = 3'd1;
  localparam req_t REQ_RETRIEVE = 3'd2;
  localparam req_t REQ_CLEAR    = 3'd3;
  localparam req_t REQ_CRESET   = 3'd4;
  localparam req_t REQ_CNEXT    = 3'd5;

  // Result status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;

endpackage

[hw/rtl/ukt_ram.sv]
module ukt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/unsorted_key_table_unit.sv]
// Unordered table of keyed records held in one single-port-write RAM.
// Input channel: in_valid/in_stall with in_req_type, in_key, in_payload.
// Result channel: out_valid/out_stall, one item for every request.
// An item is taken at a clock edge with valid high and stall low.
// The block works on one request at a time and stalls its input meanwhile.
// Insert, clear, cursor reset and unknown codes are done in the execute
// state; cursor next adds a RAM read. Retrieve and delete scan the table
// through the RAM read port, one entry per cycle, comparing keys in a
// single comparator; a delete that matches then reads the last entry and
// writes it into the freed slot. A miss ends once the last entry is checked.
// Results sit in an output register; while the receiver stalls, the block
// still accepts and works the next request and holds its result until the
// output register frees up.
// Synchronous reset empties the table and zeroes the read cursor; RAM
// contents are not cleared, no clearing pass is needed.
module unsorted_key_table_unit
  import ukt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic [DATA_BITS-1:0] in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [KEY_BITS-1:0]  out_key,
  output logic [DATA_BITS-1:0] out_payload,
  output logic [STAT_W-1:0]    out_status,
  output logic [CNT_W-1:0]     out_count,
  output logic                 out_is_full
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DREAD  = 3'd3;
  localparam logic [2:0] S_DWRITE = 3'd4;
  localparam logic [2:0] S_CWAIT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  req_t                 req_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] pay_r;

  cnt_t count_r, count_nxt;
  cnt_t cursor_r, cursor_nxt;
  cnt_t iss_r, iss_nxt;
  idx_t chk_r, chk_nxt;
  logic chk_v_r, chk_v_nxt;
  idx_t match_r, match_nxt;

  logic                 res_found_r, res_found_nxt;
  logic [KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [DATA_BITS-1:0] res_pay_r, res_pay_nxt;
  status_t              res_status_r, res_status_nxt;

  logic                 out_valid_r;
  logic                 out_found_r;
  logic [KEY_BITS-1:0]  out_key_r;
  logic [DATA_BITS-1:0] out_pay_r;
  status_t              out_status_r;
  cnt_t                 out_count_r;

  logic   ram_we;
  idx_t   ram_waddr;
  entry_t ram_wdata;
  idx_t   ram_raddr;
  entry_t ram_rdata;

  logic in_take;
  logic slot_free;
  logic load_out;
  logic rd_hit;
  logic last_chk;

  ukt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == S_DONE) && slot_free;

  assign rd_hit   = chk_v_r && (ram_rdata.key == key_r);
  assign last_chk = chk_v_r && (cnt_t'(chk_r) == count_r - cnt_t'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    chk_v_nxt      = chk_v_r;
    match_nxt      = match_r;
    res_found_nxt  = res_found_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wdata      = '{key: key_r, payload: pay_r};
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_found_nxt  = 1'b0;
        res_key_nxt    = '0;
        res_pay_nxt    = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
        case (req_r)
          REQ_INSERT: begin
            if (count_r < cnt_t'(CAPACITY)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + cnt_t'(1);
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
          REQ_DELETE, REQ_RETRIEVE: begin
            if (count_r == '0) begin
              res_status_nxt = ST_NOTFOUND;
            end else begin
              // Entry 0 is read here and checked in the first scan cycle.
              ram_raddr = '0;
              iss_nxt   = cnt_t'(1);
              chk_nxt   = '0;
              chk_v_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          REQ_CLEAR: begin
            count_nxt = '0;
          end
          REQ_CRESET: begin
            cursor_nxt = '0;
          end
          REQ_CNEXT: begin
            if (cursor_r < count_r) begin
              ram_raddr = cursor_r[IDX_W-1:0];
              state_nxt = S_CWAIT;
            end else begin
              res_status_nxt = ST_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (rd_hit) begin
          if (req_r == REQ_RETRIEVE) begin
            res_found_nxt = 1'b1;
            res_key_nxt   = ram_rdata.key;
            res_pay_nxt   = ram_rdata.payload;
            state_nxt     = S_DONE;
          end else begin
            match_nxt = chk_r;
            state_nxt = S_DREAD;
          end
        end else if (last_chk) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else if (iss_r < count_r) begin
          ram_raddr = iss_r[IDX_W-1:0];
          iss_nxt   = iss_r + cnt_t'(1);
          chk_nxt   = iss_r[IDX_W-1:0];
          chk_v_nxt = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
      end
      S_DREAD: begin
        ram_raddr = idx_t'(count_r - cnt_t'(1));
      end
      S_DWRITE: begin
        // The last entry moves into the slot of the deleted one.
        ram_we        = 1'b1;
        ram_waddr     = match_r;
        ram_wdata     = ram_rdata;
        count_nxt     = count_r - cnt_t'(1);
        res_found_nxt = 1'b1;
        state_nxt     = S_DONE;
      end
      S_CWAIT: begin
        res_found_nxt = 1'b1;
        res_key_nxt   = ram_rdata.key;
        res_pay_nxt   = ram_rdata.payload;
        cursor_nxt    = cursor_r + cnt_t'(1);
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_DREAD) begin
      state_nxt = S_DWRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      chk_v_r  <= chk_v_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req_type;
      key_r <= in_key;
      pay_r <= in_payload;
    end
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    match_r      <= match_nxt;
    res_found_r  <= res_found_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_found_r  <= res_found_r;
      out_key_r    <= res_key_r;
      out_pay_r    <= res_pay_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_key     = out_key_r;
  assign out_payload = out_pay_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;
  assign out_is_full = (out_count_r == cnt_t'(CAPACITY));

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_scan_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_v_r) |-> (cnt_t'(chk_r) < count_r))
    else $error("scan checks an entry beyond the table");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWRITE) |=> (count_r + cnt_t'(1) == $past(count_r)))
    else $error("delete did not remove exactly one entry");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !slot_free) |=> (state_r == S_DONE))
    else $error("result left its holding state while output was busy");
`endif

endmodule
